// ===== hdl/itc_pkg.sv =====
// Shared types, constants and helpers for the impact trigger and capture block.
// Depends on nothing; every other file in hdl imports it.
`default_nettype none

package itc_pkg;

    // Capture buffer size and the widths that follow from it.
    localparam int CAPTURE_DEPTH = 32;
    localparam int ADDR_W        = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
    localparam int COUNT_W       = $clog2(CAPTURE_DEPTH + 1);

    // Sample and result field widths.
    localparam int RAW_W   = 13;
    localparam int AXIS_W  = 8;
    localparam int LEVEL_W = 8;
    localparam int KIND_W  = 2;

    // Q8.8 filter values, their squares and the magnitude.
    localparam int FRAC_W = 8;
    localparam int FILT_W = 16;
    localparam int SUM_W  = 32;
    localparam int MAG_W  = 16;

    // Filter update: floor((9*f + 256*v + 5) / 10) through a reciprocal multiply.
    localparam int NUM_W    = 19;
    localparam int RECIP_SH = 23;
    localparam int RECIP_W  = 20;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + 9) / 10);
    localparam int PROD_W   = NUM_W + RECIP_W;

    // Square root unit.
    localparam int ROOT_STEPS = MAG_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);
    localparam int REM_W      = MAG_W + 4;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_RATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CAPT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEAK = 2'd2;

    // Three absolute axis counts; element 2 is x, 1 is y, 0 is z.
    typedef logic [2:0][AXIS_W-1:0] axis_vec_t;

    // Control into and status out of the filter and magnitude engine.
    typedef struct packed {
        logic start;
        logic seed;
    } fmag_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] mag;
    } fmag_stat_t;

    // Engine sequencer states.
    typedef enum logic [2:0] {
        FM_IDLE,
        FM_NUM,
        FM_MUL,
        FM_UPD,
        FM_SQR,
        FM_ACC,
        FM_GO,
        FM_ROOT
    } fmag_state_t;

    // Top level control states.
    typedef enum logic [2:0] {
        T_IDLE,
        T_WATCH,
        T_TRIG,
        T_READ,
        T_START,
        T_DUMP,
        T_EMIT1,
        T_EMIT2
    } top_state_t;

    // Keep bits 12..5 as a signed count and take its absolute value (0..128).
    function automatic logic [AXIS_W-1:0] reduce_axis(input logic [RAW_W-1:0] raw);
        logic [AXIS_W-1:0] r;
        r = raw[RAW_W-1:RAW_W-AXIS_W];
        return r[AXIS_W-1] ? AXIS_W'(9'd256 - {1'b0, r}) : r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/itc_store.sv =====
// Capture buffer: one write port and one registered read port.
// Depends on itc_pkg for depth and entry format.
`default_nettype none

module itc_store (
    input  wire                    clk,
    input  wire                    wr_en,
    input  wire [itc_pkg::ADDR_W-1:0] wr_addr,
    input  itc_pkg::axis_vec_t     wr_data,
    input  wire                    rd_en,
    input  wire [itc_pkg::ADDR_W-1:0] rd_addr,
    output itc_pkg::axis_vec_t     rd_data
);
    import itc_pkg::*;

    axis_vec_t mem [CAPTURE_DEPTH];
    axis_vec_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered on a read enable.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/itc_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Depends on itc_pkg for widths.
`default_nettype none

module itc_sqrt (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire [itc_pkg::SUM_W-1:0]  radicand,
    output logic                      done,
    output logic [itc_pkg::MAG_W-1:0] root
);
    import itc_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    op_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [MAG_W-1:0]    root_reg;

    logic [REM_W-1:0]    rem_shift;
    logic [REM_W-1:0]    trial;
    logic                fits;

    // One restoring step: bring down two bits and try the next root bit.
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], op_reg[SUM_W-1:SUM_W-2]};
        trial     = REM_W'({root_reg, 2'b01});
        fits      = (rem_shift >= trial);
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= {op_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[MAG_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hdl/itc_fmag.sv =====
// Per-axis exponential filter and vector magnitude engine, one axis at a time.
// Depends on itc_pkg and instantiates itc_sqrt.
`default_nettype none

module itc_fmag (
    input  wire                 clk,
    input  wire                 rst_n,
    input  itc_pkg::fmag_ctrl_t ctrl,
    input  itc_pkg::axis_vec_t  v_in,
    output itc_pkg::fmag_stat_t stat
);
    import itc_pkg::*;

    fmag_state_t       state_reg;
    fmag_state_t       state_next;

    logic [1:0]        ax_reg;
    logic              seed_reg;
    axis_vec_t         v_reg;
    logic [FILT_W-1:0] f_reg [3];
    logic [NUM_W-1:0]  num_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sq_reg;
    logic [SUM_W-1:0]  acc_reg;

    logic [FILT_W-1:0] f_cur;
    logic [AXIS_W-1:0] v_cur;
    logic              root_start;
    logic              root_done;
    logic [MAG_W-1:0]  root_val;

    assign f_cur = f_reg[ax_reg];
    assign v_cur = v_reg[ax_reg];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FM_IDLE: if (ctrl.start) state_next = FM_NUM;
            FM_NUM:  state_next = FM_MUL;
            FM_MUL:  state_next = FM_UPD;
            FM_UPD:  state_next = FM_SQR;
            FM_SQR:  state_next = FM_ACC;
            FM_ACC:  state_next = (ax_reg == 2'd2) ? FM_GO : FM_NUM;
            FM_GO:   state_next = FM_ROOT;
            FM_ROOT: if (root_done) state_next = FM_IDLE;
            default: state_next = FM_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        root_start = (state_reg == FM_GO);
        stat.done  = (state_reg == FM_ROOT) && root_done;
        stat.mag   = root_val;
    end

    // Sequencer state and axis counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FM_IDLE;
            ax_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == FM_IDLE && ctrl.start)
            begin
                ax_reg <= '0;
            end
            else if (state_reg == FM_ACC && ax_reg != 2'd2)
            begin
                ax_reg <= ax_reg + 1'b1;
            end
        end
    end

    // Filter update and sum of squares datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg[0] <= '0;
            f_reg[1] <= '0;
            f_reg[2] <= '0;
        end
        else if (state_reg == FM_UPD)
        begin
            f_reg[ax_reg] <= seed_reg ? {v_cur, {FRAC_W{1'b0}}}
                                      : prod_reg[RECIP_SH +: FILT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            FM_IDLE:
            begin
                if (ctrl.start)
                begin
                    v_reg    <= v_in;
                    seed_reg <= ctrl.seed;
                    acc_reg  <= '0;
                end
            end
            FM_NUM:
            begin
                // 9*f + 256*v + 5
                num_reg <= NUM_W'({f_cur, 3'b000}) + NUM_W'(f_cur)
                         + NUM_W'({v_cur, {FRAC_W{1'b0}}}) + NUM_W'(5);
            end
            FM_MUL:
            begin
                prod_reg <= PROD_W'(num_reg) * PROD_W'(RECIP);
            end
            FM_SQR:
            begin
                sq_reg <= SUM_W'(f_cur) * SUM_W'(f_cur);
            end
            FM_ACC:
            begin
                acc_reg <= acc_reg + sq_reg;
            end
            default:
            begin
            end
        endcase
    end

    itc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (acc_reg),
        .done     (root_done),
        .root     (root_val)
    );

endmodule

`default_nettype wire

// ===== hdl/impact_trigger_capture_core.sv =====
// Impact trigger and capture top level; depends on itc_pkg, itc_store and itc_fmag.
// A watch sample runs a filter update and a square for each of the three axes, starts
// the root, runs the square root, then reports a trigger or goes back to idle.
// A trigger result waits for a free output register; no new sample is taken until idle.
// A capture sample is stored from idle; a dump filters and emits each entry, then the peak.
// Reset (asynchronous, active low) returns to watch mode with threshold 12.
`default_nettype none

module impact_trigger_capture_core (
    input  wire                          clk,
    input  wire                          rst_n,
    // Configuration write channel.
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [itc_pkg::LEVEL_W-1:0]   cfg_data,
    // Sample channel.
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire signed [itc_pkg::RAW_W-1:0] accel_x,
    input  wire signed [itc_pkg::RAW_W-1:0] accel_y,
    input  wire signed [itc_pkg::RAW_W-1:0] accel_z,
    // Result channel.
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [itc_pkg::KIND_W-1:0]   kind,
    output logic [itc_pkg::LEVEL_W-1:0]  magnitude,
    output logic                         final_res
);
    import itc_pkg::*;

    top_state_t         state_reg;
    top_state_t         state_next;

    logic [LEVEL_W-1:0] level_reg;
    logic               capture_mode_reg;
    logic               seeded_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ADDR_W-1:0]  k_reg;
    logic [MAG_W-1:0]   peak_reg;

    logic               out_valid_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [LEVEL_W-1:0] mag_out_reg;
    logic               final_reg;

    logic               in_acc;
    logic               out_free;
    logic               count_full;
    logic               k_last;
    logic               hit;
    axis_vec_t          reduced;
    axis_vec_t          rd_data;
    axis_vec_t          eng_v;
    fmag_ctrl_t         eng_ctrl;
    fmag_stat_t         eng_stat;
    logic               store_we;
    logic               store_re;
    logic               out_load;
    logic [KIND_W-1:0]  load_kind;
    logic [LEVEL_W-1:0] load_mag;
    logic               load_final;

    // Sample reduction and status terms.
    always_comb
    begin
        reduced[2] = reduce_axis(accel_x);
        reduced[1] = reduce_axis(accel_y);
        reduced[0] = reduce_axis(accel_z);
        in_acc     = in_valid && in_ready;
        out_free   = !out_valid_reg || out_ready;
        count_full = (count_reg == COUNT_W'(CAPTURE_DEPTH));
        k_last     = (k_reg == ADDR_W'(CAPTURE_DEPTH - 1));
        hit        = (eng_stat.mag[MAG_W-1:FRAC_W] >= level_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (in_acc)
                begin
                    if (!capture_mode_reg)
                    begin
                        state_next = T_WATCH;
                    end
                    else if (count_full)
                    begin
                        state_next = T_READ;
                    end
                end
            end
            T_WATCH: if (eng_stat.done) state_next = hit ? T_TRIG : T_IDLE;
            T_TRIG:  if (out_free) state_next = T_IDLE;
            T_READ:  state_next = T_START;
            T_START: state_next = T_DUMP;
            T_DUMP:  if (eng_stat.done) state_next = T_EMIT1;
            T_EMIT1: if (out_free) state_next = k_last ? T_EMIT2 : T_READ;
            T_EMIT2: if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        in_ready       = (state_reg == T_IDLE);
        cfg_ready      = 1'b1;
        store_we       = in_acc && capture_mode_reg && !count_full;
        store_re       = (state_reg == T_READ);
        eng_ctrl.start = (in_acc && !capture_mode_reg) || (state_reg == T_START);
        eng_ctrl.seed  = (state_reg == T_IDLE) ? !seeded_reg : (k_reg == '0);
        eng_v          = (state_reg == T_IDLE) ? reduced : rd_data;
        out_load       = 1'b0;
        load_kind      = KIND_RATE;
        load_mag       = '0;
        load_final     = 1'b0;
        case (state_reg)
            T_TRIG:
            begin
                out_load   = out_free;
                load_kind  = KIND_RATE;
                load_final = 1'b1;
            end
            T_EMIT1:
            begin
                out_load  = out_free;
                load_kind = KIND_CAPT;
                load_mag  = eng_stat.mag[MAG_W-1:FRAC_W];
            end
            T_EMIT2:
            begin
                out_load   = out_free;
                load_kind  = KIND_PEAK;
                load_mag   = peak_reg[MAG_W-1:FRAC_W];
                load_final = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // State, mode, seed flag, counters, threshold and peak.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            level_reg        <= LEVEL_W'(12);
            capture_mode_reg <= 1'b0;
            seeded_reg       <= 1'b0;
            count_reg        <= '0;
            k_reg            <= '0;
            peak_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                level_reg <= cfg_data;
            end
            if (store_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (in_acc && capture_mode_reg && count_full)
                    begin
                        k_reg    <= '0;
                        peak_reg <= '0;
                    end
                end
                T_WATCH:
                begin
                    if (eng_stat.done)
                    begin
                        seeded_reg <= !hit;
                        if (hit)
                        begin
                            capture_mode_reg <= 1'b1;
                            count_reg        <= '0;
                            peak_reg         <= '0;
                        end
                    end
                end
                T_DUMP:
                begin
                    if (eng_stat.done && eng_stat.mag > peak_reg)
                    begin
                        peak_reg <= eng_stat.mag;
                    end
                end
                T_EMIT1:
                begin
                    if (out_free)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                T_EMIT2:
                begin
                    if (out_free)
                    begin
                        capture_mode_reg <= 1'b0;
                        seeded_reg       <= 1'b0;
                        count_reg        <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload of the transaction.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg    <= load_kind;
            mag_out_reg <= load_mag;
            final_reg   <= load_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign magnitude = mag_out_reg;
    assign final_res = final_reg;

    itc_store u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (reduced),
        .rd_en   (store_re),
        .rd_addr (k_reg),
        .rd_data (rd_data)
    );

    itc_fmag u_fmag (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (eng_ctrl),
        .v_in  (eng_v),
        .stat  (eng_stat)
    );

endmodule

`default_nettype wire
